@@ rtl/deferred_action_queue_top_assert.svh @@
// Assertion macros for the deferred action queue, clocked on clk, disabled in rst.
`ifndef DEFERRED_ACTION_QUEUE_TOP_ASSERT_SVH
`define DEFERRED_ACTION_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication.
`define DAQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/daq_pkg.sv @@
// Shared types and constants of the deferred action queue.
package daq_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 8;
  localparam int unsigned DEF_MAX_WORDS   = 8;
  localparam int unsigned MAX_SLOTS       = 8;
  localparam int unsigned SLOT_W          = 3;
  localparam int unsigned RESULT_LIMIT    = 8;
  localparam int unsigned REL_W           = $clog2(RESULT_LIMIT);

  typedef enum logic {
    CMD_HOLD   = 1'b0,
    CMD_RETIRE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_HOLD    = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_NONE    = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_RETIRE
  } state_t;

  typedef struct packed {
    logic [31:0]       tag;
    logic [7:0]        handler;
    logic [15:0]       m_number;
    logic [7:0]        subcode;
    logic [7:0]        word_count;
    logic              has_text;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        payload;
  } daq_entry_t;

  typedef struct packed {
    kind_t             kind;
    logic              accepted;
    logic [7:0]        handler;
    logic [15:0]       m_number;
    logic [7:0]        subcode;
    logic [7:0]        word_count;
    logic              has_text;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        payload;
    logic              last;
  } daq_result_t;

endpackage

@@ rtl/daq_cell.sv @@
// One queue cell: holds an entry, loads a new one or takes its neighbour's on a pop.
module daq_cell (
  input  logic                clk,
  input  logic                load,
  input  logic                shift,
  input  daq_pkg::daq_entry_t load_data,
  input  daq_pkg::daq_entry_t shift_in,
  output daq_pkg::daq_entry_t data
);
  import daq_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end else if (shift) begin
      data <= shift_in;
    end
  end

endmodule

@@ rtl/daq_slot_map.sv @@
// Text slot bitmap: finds the lowest free slot, claims and frees slots.
module daq_slot_map #(
  parameter int unsigned SLOTS = daq_pkg::MAX_SLOTS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       claim,
  input  logic                       release_en,
  input  logic [daq_pkg::SLOT_W-1:0] release_slot,
  output logic                       free_found,
  output logic [daq_pkg::SLOT_W-1:0] free_slot
);
  import daq_pkg::*;

  logic [SLOTS-1:0] slot_taken;
  logic [SLOTS-1:0] slot_taken_next;

  // Scan from the top so the lowest free slot wins.
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_taken[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    slot_taken_next = slot_taken;
    for (int i = 0; i < SLOTS; i++) begin
      if (claim && free_found && free_slot == SLOT_W'(i)) begin
        slot_taken_next[i] = 1'b1;
      end
      if (release_en && release_slot == SLOT_W'(i)) begin
        slot_taken_next[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_taken <= '0;
    end else begin
      slot_taken <= slot_taken_next;
    end
  end

endmodule

@@ rtl/deferred_action_queue_top.sv @@
// Deferred action queue: a transaction is taken when start is high and busy is low. A hold
// transaction (cmd 0) is answered in the next cycle by a single result of kind 0 (accepted 1
// if stored, 0 if the queue was full, no text slot was free or word_count exceeded
// MAX_WORDS); busy stays low, so holds may be issued every cycle. A retire transaction
// (cmd 1) raises busy and emits results, one per cycle: each due front entry (tag at or
// below block_number) as kind 1, in queue order, at most eight, or one result of kind 2
// when nothing is due; last marks the final one. The pace of a retire is set by the cell
// chain, which pops one entry per cycle. Results appear on the output ports for exactly
// one cycle, flagged by result_strobe, and cannot be held off: the receiver must take
// each one as it comes.
module deferred_action_queue_top #(
  parameter int unsigned QUEUE_DEPTH = daq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned MAX_WORDS   = daq_pkg::DEF_MAX_WORDS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cmd,
  input  logic [31:0]                block_number,
  input  logic [7:0]                 handler_id,
  input  logic [15:0]                m_number,
  input  logic [7:0]                 subcode,
  input  logic [7:0]                 word_count,
  input  logic                       has_text,
  input  logic [7:0]                 payload_ref,
  output logic                       result_strobe,
  output daq_pkg::kind_t             kind,
  output logic                       accepted,
  output logic [7:0]                 out_handler,
  output logic [15:0]                out_m_number,
  output logic [7:0]                 out_subcode,
  output logic [7:0]                 out_word_count,
  output logic                       out_has_text,
  output logic [daq_pkg::SLOT_W-1:0] text_slot,
  output logic [7:0]                 out_payload,
  output logic                       last
);
  import daq_pkg::*;

  `include "deferred_action_queue_top_assert.svh"

  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SLOT_COUNT = (QUEUE_DEPTH < MAX_SLOTS) ? QUEUE_DEPTH : MAX_SLOTS;

  // Control state
  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [REL_W-1:0]   rel_cnt;
  logic [REL_W-1:0]   rel_cnt_next;
  logic               res_valid;
  logic               res_valid_next;

  // Payload registers
  logic [31:0]        finished;
  logic [31:0]        finished_next;
  daq_result_t        res;
  daq_result_t        res_next;

  // Cell chain
  daq_entry_t                 cell_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]     cell_load;
  logic                       shift;
  daq_entry_t                 hold_entry;
  logic                       front_due;
  logic                       second_due;

  // Hold decision and slot map handshake
  logic                       hold_fits;
  logic                       hold_ok;
  logic                       free_found;
  logic [SLOT_W-1:0]          free_slot;
  logic                       claim;
  logic                       rel_en;

  // ---------------------------------------------------------------------------
  // Text slot bitmap
  // ---------------------------------------------------------------------------
  assign claim = hold_ok && has_text;

  daq_slot_map #(
    .SLOTS(SLOT_COUNT)
  ) u_slot_map (
    .clk         (clk),
    .rst         (rst),
    .claim       (claim),
    .release_en  (rel_en),
    .release_slot(cell_q[0].slot),
    .free_found  (free_found),
    .free_slot   (free_slot)
  );

  // ---------------------------------------------------------------------------
  // Cell chain: cell 0 is the front. A hold loads the cell at the fill count; a
  // pop moves every cell one place towards the front.
  // ---------------------------------------------------------------------------
  always_comb begin
    hold_entry.tag        = block_number;
    hold_entry.handler    = handler_id;
    hold_entry.m_number   = m_number;
    hold_entry.subcode    = subcode;
    hold_entry.word_count = word_count;
    hold_entry.has_text   = has_text;
    hold_entry.slot       = has_text ? free_slot : '0;
    hold_entry.payload    = payload_ref;
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    assign cell_load[g] = hold_ok && (count == CNT_W'(g));

    if (g < QUEUE_DEPTH - 1) begin : g_mid
      daq_cell u_cell (
        .clk      (clk),
        .load     (cell_load[g]),
        .shift    (shift),
        .load_data(hold_entry),
        .shift_in (cell_q[g + 1]),
        .data     (cell_q[g])
      );
    end else begin : g_tail
      // The tail entry falls out of range on a pop; its content is then never read.
      daq_cell u_cell (
        .clk      (clk),
        .load     (cell_load[g]),
        .shift    (shift),
        .load_data(hold_entry),
        .shift_in (cell_q[g]),
        .data     (cell_q[g])
      );
    end
  end

  // Look at the front and the entry behind it, so last is known when the front leaves.
  assign front_due = (count != '0) && (cell_q[0].tag <= finished);

  if (QUEUE_DEPTH > 1) begin : g_second
    assign second_due = (count > CNT_W'(1)) && (cell_q[1].tag <= finished);
  end else begin : g_no_second
    assign second_due = 1'b0;
  end

  assign hold_fits = (count < CNT_W'(QUEUE_DEPTH)) && (!has_text || free_found) &&
                     (word_count <= 8'(MAX_WORDS));

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rel_cnt   <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rel_cnt   <= rel_cnt_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    finished <= finished_next;
    res      <= res_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    rel_cnt_next   = rel_cnt;
    finished_next  = finished;
    res_next       = res;
    res_valid_next = 1'b0;
    hold_ok        = 1'b0;
    shift          = 1'b0;
    rel_en         = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (cmd == CMD_HOLD) begin
            // Answer the hold next cycle; append only when everything fits.
            hold_ok           = hold_fits;
            res_valid_next    = 1'b1;
            res_next          = '0;
            res_next.kind     = KIND_HOLD;
            res_next.accepted = hold_fits;
            res_next.has_text = hold_fits && has_text;
            res_next.slot     = (hold_fits && has_text) ? free_slot : '0;
            res_next.last     = 1'b1;
            if (hold_fits) begin
              count_next = count + CNT_W'(1);
            end
          end else begin
            finished_next = block_number;
            rel_cnt_next  = '0;
            state_next    = ST_RETIRE;
          end
        end
      end

      ST_RETIRE: begin
        res_valid_next = 1'b1;
        res_next       = '0;
        if (front_due) begin
          // Pop the front, free its slot and release it.
          shift               = 1'b1;
          rel_en              = cell_q[0].has_text;
          count_next          = count - CNT_W'(1);
          rel_cnt_next        = rel_cnt + REL_W'(1);
          res_next.kind       = KIND_RELEASE;
          res_next.handler    = cell_q[0].handler;
          res_next.m_number   = cell_q[0].m_number;
          res_next.subcode    = cell_q[0].subcode;
          res_next.word_count = cell_q[0].word_count;
          res_next.has_text   = cell_q[0].has_text;
          res_next.slot       = cell_q[0].slot;
          res_next.payload    = cell_q[0].payload;
          res_next.last       = (rel_cnt == REL_W'(RESULT_LIMIT - 1)) || !second_due;
          if (res_next.last) begin
            state_next = ST_IDLE;
          end
        end else begin
          // Only reached before any release: report that nothing is due.
          res_next.kind = KIND_NONE;
          res_next.last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  assign busy           = (state == ST_RETIRE);
  assign result_strobe  = res_valid;
  assign kind           = res.kind;
  assign accepted       = res.accepted;
  assign out_handler    = res.handler;
  assign out_m_number   = res.m_number;
  assign out_subcode    = res.subcode;
  assign out_word_count = res.word_count;
  assign out_has_text   = res.has_text;
  assign text_slot      = res.slot;
  assign out_payload    = res.payload;
  assign last           = res.last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `DAQ_ASSERT_IMP(a_count_bound, 1'b1, count <= CNT_W'(QUEUE_DEPTH), "fill count above depth")
  `DAQ_ASSERT_NEXT(a_pop_count, shift, count == $past(count) - CNT_W'(1), "pop lost an entry")
  `DAQ_ASSERT_IMP(a_hold_idle, res_valid && kind == KIND_HOLD, state == ST_IDLE, "hold in retire")
  `DAQ_ASSERT_IMP(a_last_idle, res_valid && last && kind != KIND_HOLD, state == ST_IDLE, "no last")

endmodule

@@ test/daq_checker.sv @@
// Checker for the deferred action queue: predicts every result and compares it on arrival.
module daq_checker #(
  parameter int unsigned QUEUE_DEPTH = daq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned MAX_WORDS   = daq_pkg::DEF_MAX_WORDS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       cmd,
  input  logic [31:0]                block_number,
  input  logic [7:0]                 handler_id,
  input  logic [15:0]                m_number,
  input  logic [7:0]                 subcode,
  input  logic [7:0]                 word_count,
  input  logic                       has_text,
  input  logic [7:0]                 payload_ref,
  input  logic                       result_strobe,
  input  daq_pkg::kind_t             kind,
  input  logic                       accepted,
  input  logic [7:0]                 out_handler,
  input  logic [15:0]                out_m_number,
  input  logic [7:0]                 out_subcode,
  input  logic [7:0]                 out_word_count,
  input  logic                       out_has_text,
  input  logic [daq_pkg::SLOT_W-1:0] text_slot,
  input  logic [7:0]                 out_payload,
  input  logic                       last,
  output int                         fail_count,
  output int                         pending_results
);
  import daq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOT_COUNT = (QUEUE_DEPTH < MAX_SLOTS) ? QUEUE_DEPTH : MAX_SLOTS;

  daq_entry_t           held_actions[$];
  logic [MAX_SLOTS-1:0] slot_busy;
  daq_result_t          awaited_results[$];

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Append the action unless the queue is full, no slot is free or it has too many words.
  task automatic predict_hold();
    daq_result_t       res;
    daq_entry_t        ent;
    logic              ok;
    logic [SLOT_W-1:0] slot;
    res      = '0;
    res.kind = KIND_HOLD;
    res.last = 1'b1;
    slot     = '0;
    ok       = (held_actions.size() < QUEUE_DEPTH);
    if (ok && has_text) begin
      ok = 1'b0;
      // Scan downwards so the lowest free slot wins.
      for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
        if (!slot_busy[s]) begin
          slot = s[SLOT_W-1:0];
          ok   = 1'b1;
        end
      end
    end
    if (ok && (word_count > MAX_WORDS)) ok = 1'b0;
    if (ok) begin
      if (has_text) slot_busy[slot] = 1'b1;
      ent.tag        = block_number;
      ent.handler    = handler_id;
      ent.m_number   = m_number;
      ent.subcode    = subcode;
      ent.word_count = word_count;
      ent.has_text   = has_text;
      ent.slot       = has_text ? slot : '0;
      ent.payload    = payload_ref;
      held_actions   = {held_actions, ent};
      res.accepted = 1'b1;
      res.has_text = has_text;
      res.slot     = ent.slot;
    end
    awaited_results = {awaited_results, res};
  endtask

  // Pop due front entries in order; an entry not yet due blocks those behind it.
  task automatic predict_retire();
    daq_result_t res;
    daq_entry_t  head;
    int unsigned due_cnt;
    due_cnt = 0;
    while (due_cnt < RESULT_LIMIT && due_cnt < held_actions.size() &&
           held_actions[due_cnt].tag <= block_number)
      due_cnt++;
    if (due_cnt == 0) begin
      res      = '0;
      res.kind = KIND_NONE;
      res.last = 1'b1;
      awaited_results = {awaited_results, res};
    end
    for (int unsigned k = 0; k < due_cnt; k++) begin
      head = held_actions.pop_front();
      if (head.has_text) slot_busy[head.slot] = 1'b0;
      res            = '0;
      res.kind       = KIND_RELEASE;
      res.handler    = head.handler;
      res.m_number   = head.m_number;
      res.subcode    = head.subcode;
      res.word_count = head.word_count;
      res.has_text   = head.has_text;
      res.slot       = head.slot;
      res.payload    = head.payload;
      res.last       = (k == due_cnt - 1);
      awaited_results = {awaited_results, res};
    end
  endtask

  initial begin
    fail_count      = 0;
    pending_results = 0;
    slot_busy       = '0;
  end

  always @(posedge clk) begin
    daq_result_t want;
    if (rst) begin
      held_actions.delete();
      awaited_results.delete();
      slot_busy = '0;
    end else begin
      if (result_strobe) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result of kind %0d", kind));
        end else begin
          want = awaited_results.pop_front();
          check_field("kind", 32'(kind), 32'(want.kind));
          check_field("accepted", 32'(accepted), 32'(want.accepted));
          check_field("out_handler", 32'(out_handler), 32'(want.handler));
          check_field("out_m_number", 32'(out_m_number), 32'(want.m_number));
          check_field("out_subcode", 32'(out_subcode), 32'(want.subcode));
          check_field("out_word_count", 32'(out_word_count), 32'(want.word_count));
          check_field("out_has_text", 32'(out_has_text), 32'(want.has_text));
          check_field("text_slot", 32'(text_slot), 32'(want.slot));
          check_field("out_payload", 32'(out_payload), 32'(want.payload));
          check_field("last", 32'(last), 32'(want.last));
        end
      end
      if (start && !busy) begin
        if (cmd == CMD_HOLD) predict_hold();
        else predict_retire();
      end
    end
    pending_results = awaited_results.size();
  end

endmodule

@@ test/tb_top.sv @@
// Top-level testbench of the deferred action queue: stimulus, clock, reset and verdict.
module tb_top;
  import daq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous ceiling for the watchdog on the length of a correct run.
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned ITEMS_PER_RUN = 78;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start;
  logic              busy;
  logic              cmd;
  logic [31:0]       block_number;
  logic [7:0]        handler_id;
  logic [15:0]       m_number;
  logic [7:0]        subcode;
  logic [7:0]        word_count;
  logic              has_text;
  logic [7:0]        payload_ref;
  logic              result_strobe;
  kind_t             kind;
  logic              accepted;
  logic [7:0]        out_handler;
  logic [15:0]       out_m_number;
  logic [7:0]        out_subcode;
  logic [7:0]        out_word_count;
  logic              out_has_text;
  logic [SLOT_W-1:0] text_slot;
  logic [7:0]        out_payload;
  logic              last;

  int          fail_count;
  int          pending_results;
  int unsigned cycle_cnt = 0;
  int unsigned idle_pct  = 0;
  int unsigned hold_cnt  = 0;
  int unsigned retire_cnt = 0;
  logic [31:0] block_cursor;

  always #1 clk = ~clk;

  deferred_action_queue_top u_dut (
    .clk, .rst, .start, .busy, .cmd, .block_number, .handler_id, .m_number, .subcode,
    .word_count, .has_text, .payload_ref, .result_strobe, .kind, .accepted, .out_handler,
    .out_m_number, .out_subcode, .out_word_count, .out_has_text, .text_slot, .out_payload,
    .last
  );

  daq_checker u_checker (
    .clk, .rst, .start, .busy, .cmd, .block_number, .handler_id, .m_number, .subcode,
    .word_count, .has_text, .payload_ref, .result_strobe, .kind, .accepted, .out_handler,
    .out_m_number, .out_subcode, .out_word_count, .out_has_text, .text_slot, .out_payload,
    .last, .fail_count, .pending_results
  );

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending_results);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Scramble every payload field while start is low; the block must ignore it.
  task automatic scramble_fields();
    cmd          = 1'($urandom_range(1));
    block_number = $urandom();
    handler_id   = 8'($urandom());
    m_number     = 16'($urandom());
    subcode      = 8'($urandom());
    word_count   = 8'($urandom());
    has_text     = 1'($urandom_range(1));
    payload_ref  = 8'($urandom());
  endtask

  // Present one transaction at the falling edge and hold it until the block takes it.
  // Idle cycles come first, one coin toss per cycle, so gaps land on every phase of a retire.
  task automatic issue(input cmd_t c, input logic [31:0] bn, input logic [7:0] h,
                       input logic [15:0] m, input logic [7:0] sub, input logic [7:0] words,
                       input logic text, input logic [7:0] pl);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      scramble_fields();
      @(negedge clk);
    end
    cmd          = c;
    block_number = bn;
    handler_id   = h;
    m_number     = m;
    subcode      = sub;
    word_count   = words;
    has_text     = text;
    payload_ref  = pl;
    start        = 1'b1;
    // Busy read here is the value of the cycle just ended, so acceptance is exact.
    do @(posedge clk); while (busy);
    if (c == CMD_HOLD) hold_cnt++;
    else retire_cnt++;
  endtask

  task automatic send_hold(input logic [31:0] tag, input logic [7:0] words, input logic text);
    issue(CMD_HOLD, tag, 8'($urandom()), 16'($urandom()), 8'($urandom()), words, text,
          8'($urandom()));
  endtask

  // Retire carries only the block number; scramble the rest.
  task automatic send_retire(input logic [31:0] finished);
    issue(CMD_RETIRE, finished, 8'($urandom()), 16'($urandom()), 8'($urandom()),
          8'($urandom()), 1'($urandom_range(1)), 8'($urandom()));
  endtask

  // Hold the sender off until every predicted result has been seen.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // Mostly well-formed traffic around a moving block cursor, so entries fall due at a steady
  // pace; a few wild tags and retires reach the upper bits and flush the queue.
  task automatic random_transaction();
    logic [31:0] tag;
    logic [7:0]  words;
    int unsigned pick;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 62) begin
      if ($urandom_range(9) == 0) tag = $urandom();
      else tag = block_cursor + $urandom_range(24);
      if ($urandom_range(99) < 85) words = 8'($urandom_range(DEF_MAX_WORDS));
      else words = 8'($urandom_range(255, DEF_MAX_WORDS + 1));
      issue(CMD_HOLD, tag, 8'($urandom()), 16'($urandom()), 8'($urandom()), words,
            1'($urandom_range(1)), 8'($urandom()));
    end else begin
      if (pick < 8) send_retire($urandom());
      else if (pick < 12) send_retire(32'hFFFF_FFFF);
      else send_retire(block_cursor + $urandom_range(12));
      block_cursor += $urandom_range(8);
    end
  endtask

  initial begin
    int unsigned idle_plan[4];
    idle_plan = '{0, 78, 27, 0};
    start = 1'b0;
    scramble_fields();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, back to back.
    idle_pct = 0;
    send_retire(32'h0000_0000);            // empty queue: nothing due
    issue(CMD_HOLD, 32'h0000_0000, 8'h00, 16'h0000, 8'h00, 8'd0, 1'b0, 8'h00);
    issue(CMD_HOLD, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 8'hFF, 8'(DEF_MAX_WORDS), 1'b1, 8'hFF);
    send_hold(32'd3, 8'(DEF_MAX_WORDS + 1), 1'b0);   // one word too many
    send_hold(32'd3, 8'd255, 1'b1);                 // too many words: rejected, no slot claimed
    send_retire(32'h0000_0000);            // releases the tag-0 entry, stops at the far tag
    send_hold(32'd5, 8'd2, 1'b1);
    send_retire(32'd10);                   // front not due blocks a due entry behind it
    for (int i = 1; i <= 6; i++) send_hold(32'(i), 8'(i), 1'b1);
    send_hold(32'd7, 8'd1, 1'b0);          // queue full: rejected
    send_retire(32'hFFFF_FFFF);            // releases the whole queue, eight results
    send_retire(32'hFFFF_FFFF);            // empty again: nothing due
    drain();

    // Random part, one block of transactions per idle profile, draining between them.
    foreach (idle_plan[p]) begin
      idle_pct     = idle_plan[p];
      block_cursor = $urandom() >> $urandom_range(31);
      for (int i = 0; i < ITEMS_PER_RUN; i++) random_transaction();
      drain();
    end

    // Let any trailing strobe surface before the verdict.
    repeat (16) @(posedge clk);
    $display("Covered %0d transactions (%0d holds, %0d retires) over four idle profiles.",
             hold_cnt + retire_cnt, hold_cnt, retire_cnt);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
